FILE: src/srsg_pkg.sv
// shared widths and a helper function for the stepper ramp step generator
// no dependencies; imported by the divider, the square root unit and the top level
package srsg_pkg;

    // speeds are signed 1/256 step/s, acceleration unsigned 1/256 step/s^2
    localparam int SPEED_W = 29;
    localparam int ACCEL_W = 28;
    localparam int POS_W   = 32;

    // shared divider: 36 bit dividend (accel << 8), divisor is a speed magnitude
    localparam int DVD_W = ACCEL_W + 8;
    localparam int DVS_W = SPEED_W;

    // square root of accel * 512, padded to an even width
    localparam int RAD_W  = ACCEL_W + 10;
    localparam int ROOT_W = RAD_W / 2;

    // default timer settings
    localparam int DEF_TICKS_PER_US = 48;
    localparam int DEF_COUNTER_MAX  = 65535;
    localparam int DEF_PULSE_US     = 3;

    localparam int PULSE_PROD_W = 12;

    // pulse high time in prescaled ticks, clamped to 2..255
    function automatic logic [7:0] pulse_for(input logic [PULSE_PROD_W-1:0] hi_ticks,
                                             input logic [2:0] div);
        logic [PULSE_PROD_W-1:0] hi;
        hi = hi_ticks >> {div, 1'b0};
        if (hi < PULSE_PROD_W'(2)) begin
            pulse_for = 8'd2;
        end else if (hi > PULSE_PROD_W'(255)) begin
            pulse_for = 8'd255;
        end else begin
            pulse_for = hi[7:0];
        end
    endfunction

endpackage

FILE: src/srsg_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on srsg_pkg for the operand widths
module srsg_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [srsg_pkg::DVD_W-1:0] i_dividend,
    input  logic [srsg_pkg::DVS_W-1:0] i_divisor,
    output logic                       o_busy,
    output logic [srsg_pkg::DVD_W-1:0] o_quotient
);
    import srsg_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    assign rem_sh  = {r_rem, r_quo[DVD_W-1]};
    assign ge      = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= r_cnt != CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule

FILE: src/srsg_sqrt.sv
// digit-by-digit integer square root, one root bit per cycle
// depends on srsg_pkg for the operand widths
module srsg_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [srsg_pkg::RAD_W-1:0]  i_radicand,
    output logic                        o_busy,
    output logic [srsg_pkg::ROOT_W-1:0] o_root
);
    import srsg_pkg::*;

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_x;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    assign rem_sh = {r_rem[REM_W-3:0], r_x[RAD_W-1:RAD_W-2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(ROOT_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= r_cnt != CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[RAD_W-3:0], 2'b00};
            r_root <= {r_root[ROOT_W-2:0], ge};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;
endmodule

FILE: src/stepper_ramp_step_generator.sv
// stepper motor step generator with a constant acceleration speed ramp
// depends on srsg_pkg, srsg_div (shared serial divider) and srsg_sqrt
//
// channel   dir  beat contents
// s_axis    in   tuser kind, tdata target_speed
// m_axis    out  one result beat per input beat
// cfg       in   write enable, index, data (acceleration, invert_direction)
//
// a step tick or a target command that ramps takes at most one 36 bit serial
// division for the ramp step (or a 19 bit square root from standstill),
// a second 36 bit division for the step period, then up to six prescaler steps
// other commands need no arithmetic, or one division when the timer keeps running
// the finished result waits in the output register; a new beat is taken meanwhile
// synchronous active-low reset clears speeds, position, timer state and config
module stepper_ramp_step_generator #(
    parameter int TICKS_PER_US = srsg_pkg::DEF_TICKS_PER_US,
    parameter int COUNTER_MAX  = srsg_pkg::DEF_COUNTER_MAX,
    parameter int PULSE_US     = srsg_pkg::DEF_PULSE_US
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // target_speed[28:0], zero fill
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // running[0] direction_cw[1] divider_index[4:2] period_count[20:5]
    // pulse_count[28:21] reload_only[29] position_out[61:30] speed_out[90:62]
    // at_speed[91], zero fill
    output logic [95:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [27:0] i_cfg_data
);
    import srsg_pkg::*;

    localparam logic [1:0] K_TICK = 2'd0;
    localparam logic [1:0] K_TARGET = 2'd1;
    localparam logic [1:0] K_STOP = 2'd2;
    localparam logic [1:0] K_HOME = 2'd3;

    localparam logic CFG_ACCEL = 1'b0;
    localparam logic CFG_INVERT = 1'b1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RAMP_GO = 4'd1;
    localparam logic [3:0] S_RAMP_WAIT = 4'd2;
    localparam logic [3:0] S_RAMP_APPLY = 4'd3;
    localparam logic [3:0] S_TIME_GO = 4'd4;
    localparam logic [3:0] S_TIME_WAIT = 4'd5;
    localparam logic [3:0] S_PRESC = 4'd6;
    localparam logic [3:0] S_FINISH = 4'd7;

    localparam logic [2:0] DIV_LAST = 3'd5;
    localparam int US_W = 24;
    localparam int TICKS_W = 32;
    localparam logic [TICKS_W-1:0] FIT_LIM = TICKS_W'(COUNTER_MAX - 2000);
    localparam logic [PULSE_PROD_W-1:0] PULSE_PROD = PULSE_PROD_W'(TICKS_PER_US * PULSE_US);
    localparam logic [DVD_W-1:0] US_SCALE = DVD_W'(256000000);
    localparam logic signed [SPEED_W-1:0] SLOW_LIMIT = SPEED_W'(12800);
    localparam logic signed [SPEED_W-1:0] SPD_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
    localparam logic signed [SPEED_W-1:0] SPD_MAX = {1'b0, {(SPEED_W-1){1'b1}}};

    logic [3:0] r_state;

    // config
    logic [ACCEL_W-1:0] r_accel;
    logic               r_invert;

    // block state
    logic signed [SPEED_W-1:0] r_cur;
    logic signed [SPEED_W-1:0] r_goal;
    logic [POS_W-1:0]          r_pos;
    logic                      r_timer;
    logic [2:0]                r_active;
    logic                      r_dir;

    // per-item working registers
    logic               r_apply;      // speed update path taken
    logic               r_timer_was;  // timer state seen by the speed update
    logic               r_restart;
    logic [TICKS_W-1:0] r_ticks;
    logic [2:0]         r_d;
    logic [2:0]         r_div;
    logic [15:0]        r_period;

    // output register
    logic        r_ovalid;
    logic [95:0] r_odata;

    // arithmetic units
    logic               div_start, div_busy;
    logic [DVD_W-1:0]   div_dvd, div_quo;
    logic [DVS_W-1:0]   div_dvs;
    logic               sq_start, sq_busy;
    logic [ROOT_W-1:0]  sq_root;

    logic signed [SPEED_W-1:0] in_t;
    logic signed [SPEED_W-1:0] goal_cmd;
    logic [SPEED_W-1:0]        cur_mag;
    logic [DVD_W-1:0]          step_amt;
    logic signed [DVD_W+2:0]   v_x, g_x, s_x, up_x, dn_x;
    logic signed [SPEED_W-1:0] ramp_v;
    logic [SPEED_W:0]          ramp_mag;
    logic                      in_acc;
    logic [2:0]                o_div;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = r_state == S_IDLE;
    assign in_t = s_axis_tdata[SPEED_W-1:0];

    // commanded goal, negation of the most negative value saturates
    always_comb begin
        if (r_invert) begin
            goal_cmd = in_t;
        end else if (in_t == SPD_MIN) begin
            goal_cmd = SPD_MAX;
        end else begin
            goal_cmd = -in_t;
        end
    end

    assign cur_mag = r_cur[SPEED_W-1] ? SPEED_W'(-r_cur) : SPEED_W'(r_cur);

    // divider serves the ramp step then the period
    assign div_start = (r_state == S_RAMP_GO && r_cur != '0) || r_state == S_TIME_GO;
    assign div_dvd   = (r_state == S_TIME_GO) ? US_SCALE : {r_accel, 8'd0};
    assign div_dvs   = cur_mag;
    assign sq_start  = r_state == S_RAMP_GO && r_cur == '0;

    srsg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    srsg_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand ({1'b0, r_accel, 9'd0}),
        .o_busy     (sq_busy),
        .o_root     (sq_root)
    );

    // ramp toward the goal, clamped at the goal
    always_comb begin
        step_amt = (r_cur == '0) ? DVD_W'(sq_root) : div_quo;
        v_x  = (DVD_W+3)'(r_cur);
        g_x  = (DVD_W+3)'(r_goal);
        s_x  = $signed({3'b000, step_amt});
        up_x = v_x + s_x;
        dn_x = v_x - s_x;
        if (r_cur < r_goal) begin
            ramp_v = (up_x > g_x) ? r_goal : up_x[SPEED_W-1:0];
        end else if (r_cur > r_goal) begin
            ramp_v = (dn_x < g_x) ? r_goal : dn_x[SPEED_W-1:0];
        end else begin
            ramp_v = r_cur;
        end
        ramp_mag = ramp_v[SPEED_W-1] ? -{ramp_v[SPEED_W-1], ramp_v}
                                     : {ramp_v[SPEED_W-1], ramp_v};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel  <= '0;
            r_invert <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ACCEL:  r_accel  <= i_cfg_data[ACCEL_W-1:0];
                CFG_INVERT: r_invert <= i_cfg_data[0];
                default:    r_invert <= r_invert;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_goal      <= '0;
            r_pos       <= '0;
            r_timer     <= 1'b0;
            r_active    <= '0;
            r_dir       <= 1'b0;
            r_apply     <= 1'b0;
            r_timer_was <= 1'b0;
            r_restart   <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            // a finishing item refills the output register itself
            if (r_ovalid && m_axis_tready && r_state != S_FINISH) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_restart <= 1'b0;
                        // speed update runs for ticks and for slow target commands
                        r_apply   <= (s_axis_tuser == K_TICK) ||
                                     (s_axis_tuser == K_TARGET && r_cur < SLOW_LIMIT);
                        unique case (s_axis_tuser)
                            K_TICK: begin
                                r_pos <= r_pos + (r_cur[SPEED_W-1] ? '1 : POS_W'(1));
                                r_timer_was <= r_timer;
                                r_state     <= S_RAMP_GO;
                            end
                            K_TARGET: begin
                                r_goal <= goal_cmd;
                                if (r_cur < SLOW_LIMIT) begin
                                    // timer stopped first, then one ramp step
                                    r_timer     <= 1'b0;
                                    r_timer_was <= 1'b0;
                                    r_state     <= S_RAMP_GO;
                                end else begin
                                    r_state <= S_TIME_GO;
                                end
                            end
                            K_STOP: begin
                                r_goal  <= '0;
                                r_cur   <= '0;
                                r_timer <= 1'b0;
                                r_state <= S_FINISH;
                            end
                            K_HOME: begin
                                r_pos   <= '0;
                                r_state <= r_timer ? S_TIME_GO : S_FINISH;
                            end
                            default: r_state <= S_FINISH;
                        endcase
                    end
                end
                S_RAMP_GO: r_state <= S_RAMP_WAIT;
                S_RAMP_WAIT: begin
                    if (!div_busy && !sq_busy) begin
                        r_state <= S_RAMP_APPLY;
                    end
                end
                S_RAMP_APPLY: begin
                    // speeds under 0.1 step/s stop the timer
                    if (ramp_mag < (SPEED_W+1)'(26)) begin
                        r_cur   <= '0;
                        r_timer <= 1'b0;
                        r_state <= S_FINISH;
                    end else begin
                        r_cur   <= ramp_v;
                        r_dir   <= !ramp_v[SPEED_W-1];
                        r_state <= S_TIME_GO;
                    end
                end
                S_TIME_GO: r_state <= S_TIME_WAIT;
                S_TIME_WAIT: begin
                    if (!div_busy) begin
                        r_ticks <= TICKS_W'(TICKS_PER_US) * TICKS_W'(div_quo[US_W-1:0]);
                        r_d     <= '0;
                        r_state <= S_PRESC;
                    end
                end
                S_PRESC: begin
                    if (r_ticks < FIT_LIM || r_d == DIV_LAST) begin
                        r_div    <= r_d;
                        r_period <= (r_ticks < FIT_LIM) ? r_ticks[15:0] : 16'(COUNTER_MAX);
                        if (r_apply) begin
                            r_restart <= !(r_d == r_active && r_timer_was);
                            r_active  <= r_d;
                            r_timer   <= 1'b1;
                        end
                        r_state <= S_FINISH;
                    end else begin
                        r_ticks <= r_ticks >> 2;
                        r_d     <= r_d + 1'b1;
                    end
                end
                S_FINISH: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_div = r_timer ? r_div : r_active;

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && (!r_ovalid || m_axis_tready)) begin
            r_odata <= {4'd0,
                        r_cur == r_goal,
                        r_cur,
                        r_pos,
                        r_timer && !r_restart,
                        pulse_for(PULSE_PROD, o_div),
                        r_timer ? r_period : 16'd0,
                        o_div,
                        r_dir,
                        r_timer};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // timer runs exactly when the reported speed is nonzero
    a_run_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[90:62] != '0)))
        else $error("running flag disagrees with speed");

    // a stopped timer reports no period
    a_stop_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[20:5] == '0))
        else $error("period reported while stopped");

    // one beat in flight: input closes right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("second beat accepted while busy");

    // the divider is never restarted mid-division
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
endmodule

FILE: bench/tb_stepper_ramp_step_generator.sv
// self-checking bench for the stepper ramp step generator: commands and ticks in,
// one status beat out per command, compared against an in-bench speed ramp predictor
`timescale 1ns / 100ps

module tb_stepper_ramp_step_generator;
    import srsg_pkg::*;

    // command kinds carried in tuser
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_TARGET = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;
    localparam logic [1:0] KIND_HOME = 2'd3;
    // config register indexes
    localparam logic REG_ACCEL = 1'b0;
    localparam logic REG_INVERT = 1'b1;

    localparam longint SPD_MAX = 268435455;
    localparam longint SPD_MIN = -268435456;
    localparam longint SLOW_SPEED = 12800;

    typedef struct packed {
        logic        at_speed;
        logic [28:0] speed;
        logic [31:0] position;
        logic        reload_only;
        logic [7:0]  pulse;
        logic [15:0] period;
        logic [2:0]  divider;
        logic        direction_cw;
        logic        running;
    } status_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [27:0] i_cfg_data = '0;

    stepper_ramp_step_generator dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    longint   cur_speed, goal_speed;
    bit [31:0] position;
    bit       timer_on;
    int       active_div;
    bit       dir_cw;
    longint   accel_reg;
    bit       keep_sign;

    status_t  expected_status[$];
    int       error_count = 0;
    bit       idle_out = 1'b1;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic longint int_sqrt(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int pulse_ticks(input int d);
        int hi;
        hi = (48 * 3) >> (2 * d);
        if (hi < 2) hi = 2;
        if (hi > 255) hi = 255;
        return hi;
    endfunction

    function automatic void step_timing(input longint v, output int d, output int per);
        longint unsigned mag, ticks;
        mag = v < 0 ? -v : v;
        if (mag == 0) mag = 1;
        ticks = 48 * ((64'd256000000 / mag) & 64'hFFFF_FFFF);
        for (int k = 0; k <= 5; k++) begin
            if (ticks < 63535) begin
                d = k;
                per = int'(ticks);
                return;
            end
            ticks >>= 2;
        end
        d = 5;
        per = 65535;
    endfunction

    function automatic longint next_ramp_speed();
        longint v, r, st;
        v = cur_speed;
        r = v;
        if (v == 0) st = longint'(int_sqrt(accel_reg * 512));
        else st = (accel_reg << 8) / (v < 0 ? -v : v);
        if (v < goal_speed) begin
            r = v + st;
            if (r > goal_speed) r = goal_speed;
        end else if (v > goal_speed) begin
            r = v - st;
            if (r < goal_speed) r = goal_speed;
        end
        return r;
    endfunction

    // returns 1 on a full timer restart
    function automatic bit set_speed(input longint v);
        int d, per;
        if ((v < 0 ? -v : v) * 10 < 256) v = 0;
        cur_speed = v;
        if (v == 0) begin
            timer_on = 0;
            return 0;
        end
        dir_cw = v >= 0;
        step_timing(v, d, per);
        if (d == active_div && timer_on) return 0;
        active_div = d;
        timer_on = 1;
        return 1;
    endfunction

    function automatic void predict_status(input logic [1:0] kind, input logic [28:0] tgt);
        bit restarted;
        longint g;
        int d, per;
        status_t s;
        restarted = 0;
        per = 0;
        case (kind)
            KIND_TICK: begin
                position += cur_speed < 0 ? 32'hFFFF_FFFF : 32'd1;
                restarted = set_speed(next_ramp_speed());
            end
            KIND_TARGET: begin
                g = longint'($signed(tgt));
                if (!keep_sign) g = -g;
                if (g > SPD_MAX) g = SPD_MAX;
                if (g < SPD_MIN) g = SPD_MIN;
                goal_speed = g;
                if (cur_speed < SLOW_SPEED) timer_on = 0;
                if (!timer_on) restarted = set_speed(next_ramp_speed());
            end
            KIND_STOP: begin
                goal_speed = 0;
                restarted = set_speed(0);
            end
            default: position = '0;
        endcase
        if (timer_on) step_timing(cur_speed, d, per);
        else d = active_div;
        s.running = timer_on;
        s.direction_cw = dir_cw;
        s.divider = d[2:0];
        s.period = per[15:0];
        s.pulse = 8'(pulse_ticks(d));
        s.reload_only = timer_on && !restarted;
        s.position = position;
        s.speed = cur_speed[28:0];
        s.at_speed = cur_speed == goal_speed;
        expected_status.push_back(s);
    endfunction

    // valid stays up across back-to-back beats and drops only for an idle gap
    task automatic send_command(input logic [1:0] kind, input logic [28:0] tgt);
        int gap;
        gap = idle_out ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {3'b000, tgt};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_status(kind, tgt);
    endtask

    task automatic write_reg(input logic idx, input logic [27:0] val);
        s_axis_tvalid <= 1'b0;
        // let the block settle before touching config
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_ACCEL) accel_reg = val;
        else keep_sign = val[0];
    endtask

    function automatic logic [28:0] rand_speed();
        case ($urandom_range(0, 5))
            0: return 29'($urandom_range(0, 60)) - 29'd30;
            1: return 29'($urandom_range(0, 40000)) - 29'd20000;
            2: return 29'($urandom_range(0, 2000000)) - 29'd1000000;
            default: return 29'($urandom);
        endcase
    endfunction

    // result side: random stalls, then compare each beat with the oldest expectation
    always @(posedge i_clk) begin
        status_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[91:0];
            if (expected_status.size() == 0) begin
                report_mismatch("unexpected beat", 0, 1);
            end else begin
                want = expected_status.pop_front();
                if (got.running !== want.running)
                    report_mismatch("running", got.running, want.running);
                if (got.direction_cw !== want.direction_cw)
                    report_mismatch("direction_cw", got.direction_cw, want.direction_cw);
                if (got.divider !== want.divider)
                    report_mismatch("divider_index", got.divider, want.divider);
                if (got.period !== want.period)
                    report_mismatch("period_count", got.period, want.period);
                if (got.pulse !== want.pulse)
                    report_mismatch("pulse_count", got.pulse, want.pulse);
                if (got.reload_only !== want.reload_only)
                    report_mismatch("reload_only", got.reload_only, want.reload_only);
                if (got.position !== want.position)
                    report_mismatch("position_out", got.position, want.position);
                if (got.speed !== want.speed)
                    report_mismatch("speed_out", $signed(got.speed), $signed(want.speed));
                if (got.at_speed !== want.at_speed)
                    report_mismatch("at_speed", got.at_speed, want.at_speed);
            end
        end
    end

    initial begin
        int stall;
        forever begin
            stall = idle_out ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // extremes, every kind, slow speeds, zero acceleration, sign handling
    task automatic test_directed();
        send_command(KIND_TICK, '0);               // zero accel from standstill
        send_command(KIND_TARGET, 29'd100000);     // negated goal, still zero accel
        write_reg(REG_ACCEL, 28'hFFF_FFFF);
        send_command(KIND_TARGET, 29'h1000_0000);  // most negative, negation saturates
        send_command(KIND_TICK, '0);
        send_command(KIND_HOME, '0);
        send_command(KIND_TICK, '0);
        send_command(KIND_STOP, '0);
        write_reg(REG_INVERT, 28'd1);
        send_command(KIND_TARGET, 29'h0FFF_FFFF);
        send_command(KIND_TICK, '0);
        send_command(KIND_TARGET, 29'd20);         // below threshold after ramp
        write_reg(REG_ACCEL, 28'd1);
        send_command(KIND_STOP, '0);
        send_command(KIND_TARGET, 29'd25);         // tiny step, speed rounds to zero
        send_command(KIND_TICK, '0);
        send_command(KIND_TARGET, 29'h1FFF_FFE0);  // small negative goal
        repeat (4) send_command(KIND_TICK, '0);
        write_reg(REG_ACCEL, 28'd50000);
        send_command(KIND_TARGET, 29'd13000);
        repeat (4) send_command(KIND_TICK, '0);
        send_command(KIND_HOME, '0);
    endtask

    // ramp profiles: a target then many ticks, with random commands mixed in
    task automatic test_random_ramps();
        int sent, n;
        sent = 0;
        while (sent < 1320) begin
            if ($urandom_range(0, 7) == 0) begin
                write_reg(REG_ACCEL, $urandom_range(0, 3) == 0 ? 28'($urandom)
                                   : 28'($urandom_range(0, 2000000)));
                write_reg(REG_INVERT, 28'($urandom_range(0, 1)));
                idle_out = $urandom_range(0, 3) == 0;
            end
            send_command(KIND_TARGET, rand_speed());
            n = $urandom_range(1, 40);
            sent += n + 1;
            repeat (n) begin
                case ($urandom_range(0, 19))
                    0: send_command(KIND_STOP, 29'($urandom));
                    1: send_command(KIND_HOME, 29'($urandom));
                    2: send_command(KIND_TARGET, rand_speed());
                    default: send_command(KIND_TICK, 29'($urandom));
                endcase
            end
        end
    endtask

    initial begin
        cur_speed = 0; goal_speed = 0; position = '0; timer_on = 0;
        active_div = 0; dir_cw = 0; accel_reg = 0; keep_sign = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        idle_out = 1'b0;
        test_random_ramps();
        s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** stepper_ramp_step_generator: PASSED **");
        end else begin
            $display("** stepper_ramp_step_generator: FAILED **");
        end
        $finish;
    end

    // watchdog well past the slowest legal run
    initial begin
        #20ms;
        $display("** stepper_ramp_step_generator: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
src/srsg_pkg.sv
src/srsg_div.sv
src/srsg_sqrt.sv
src/stepper_ramp_step_generator.sv
bench/tb_stepper_ramp_step_generator.sv
